### rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the tagged property header parser.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int NAME_W  = 24;
    localparam int SIZE_W  = 32;
    localparam int ACC_W   = 32;
    localparam int SUM_W   = 34;
    localparam int KIND_W  = 2;
    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_DONE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_NAME  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_NNUM  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_INFO  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SNAME = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SNUM  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SIZE  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ARRAY = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SKIP  = 4'd8;

    localparam logic [KIND_W-1:0] KIND_PROP     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_NAME = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EXHAUST  = 2'd3;

    localparam logic [3:0] TYPE_BOOL   = 4'd3;
    localparam logic [3:0] TYPE_STRUCT = 4'd10;

    localparam logic [2:0] CODE_SIZE1 = 3'd5;
    localparam logic [2:0] CODE_SIZE2 = 3'd6;

    localparam int MIN_REGION = 5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NAME_W-1:0] name_index;
        logic [3:0]        tag_type;
        logic [SIZE_W-1:0] payload_size;
        logic [NAME_W-1:0] value_offset;
        logic [NAME_W-1:0] struct_name_index;
        logic              struct_name_valid;
        logic              array_flag;
        logic              last;
    } pts_rec_t;

    typedef struct packed {
        logic [1:0] count;
        pts_rec_t   rec0;
        pts_rec_t   rec1;
    } pts_push_t;

    typedef struct packed {
        logic             done;
        logic             neg;
        logic [ACC_W-1:0] acc;
    } ci_t;

    function automatic logic [SIZE_W-1:0] fixed_size(input logic [2:0] code);
        logic [SIZE_W-1:0] r;
        case (code)
            3'd0:    r = 32'd1;
            3'd1:    r = 32'd2;
            3'd2:    r = 32'd4;
            3'd3:    r = 32'd12;
            3'd4:    r = 32'd16;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/pts_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_fifo
// Small result queue that takes up to two entries per cycle and gives one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module pts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_count,
    input  logic [WIDTH-1:0] push_data0,
    input  logic [WIDTH-1:0] push_data1,
    output logic             space_ok,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data,
    input  logic             out_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    wr_ptr_plus1;
    logic             pop;

    assign out_valid    = (count_reg != '0);
    assign out_data     = data_reg[rd_ptr_reg];
    assign space_ok     = (count_reg <= CW'(DEPTH - 2));
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + AW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push_count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push_count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            data_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2) begin
            data_reg[wr_ptr_plus1] <= push_data1;
        end
    end

endmodule

### rtl/pts_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_parser
// Byte-wide header walk state and the records produced by each byte.
// ----------------------------------------------------------------------------
module pts_parser #(
    parameter int POSITION_WIDTH = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_accept,
    input  logic [7:0]                data_byte,
    input  logic                      start_of_region,
    input  logic [pts_pkg::NAME_W-1:0] region_length,
    input  logic [pts_pkg::NAME_W-1:0] name_count,
    output pts_pkg::pts_push_t        push
);

    localparam int PW = POSITION_WIDTH;

    logic [pts_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [PW-1:0]               pos_reg, pos_next;
    logic [PW-1:0]               len_reg, len_next;
    logic [2:0]                  bif_reg, bif_next;
    logic [pts_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic                        neg_reg, neg_next;
    logic [pts_pkg::NAME_W-1:0]  name_reg, name_next;
    logic [7:0]                  info_reg, info_next;
    logic [pts_pkg::NAME_W:0]    struct_reg, struct_next;
    logic [pts_pkg::SIZE_W-1:0]  size_reg, size_next;
    logic [pts_pkg::SIZE_W-1:0]  skip_reg, skip_next;

    logic [PW-1:0]              p;
    logic [PW:0]                p1;
    logic [PW-1:0]              len_sample;
    pts_pkg::ci_t               ci;
    logic                       size_done;
    logic                       emit_req;
    logic [1:0]                 extra;
    logic [2:0]                 need;
    logic [pts_pkg::SUM_W-1:0]  voff;
    logic [pts_pkg::SUM_W-1:0]  next5;
    logic                       rec_valid;
    logic                       fin;
    pts_pkg::pts_rec_t          rec;
    pts_pkg::pts_rec_t          fin_rec;
    logic                       struct_ok;

    function automatic pts_pkg::ci_t ci_take(input logic [2:0] i, input logic [7:0] b,
                                             input logic [pts_pkg::ACC_W-1:0] acc,
                                             input logic neg);
        pts_pkg::ci_t r;
        r.acc  = acc;
        r.neg  = neg;
        r.done = 1'b0;
        case (i)
            3'd0: begin
                r.neg  = b[7];
                r.acc  = {26'd0, b[5:0]};
                r.done = !b[6];
            end
            3'd1: begin
                r.acc  = acc | (32'(b[6:0]) << 6);
                r.done = !b[7];
            end
            3'd2: begin
                r.acc  = acc | (32'(b[6:0]) << 13);
                r.done = !b[7];
            end
            3'd3: begin
                r.acc  = acc | (32'(b[6:0]) << 20);
                r.done = !b[7];
            end
            default: begin
                r.acc  = acc | {b[4:0], 27'd0};
                r.done = 1'b1;
            end
        endcase
        return r;
    endfunction

    assign len_sample = PW'(region_length);

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        bif_next    = bif_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        name_next   = name_reg;
        info_next   = info_reg;
        struct_next = struct_reg;
        size_next   = size_reg;
        skip_next   = skip_reg;
        p           = '0;
        p1          = '0;
        ci          = '0;
        size_done   = 1'b0;
        emit_req    = 1'b0;
        extra       = 2'd0;
        need        = 3'd4;
        voff        = '0;
        next5       = '0;
        rec_valid   = 1'b0;
        fin         = 1'b0;
        rec         = '0;
        struct_ok   = 1'b0;

        if (in_accept) begin
            if (start_of_region) begin
                phase_next  = pts_pkg::PH_NAME;
                pos_next    = '0;
                len_next    = len_sample;
                bif_next    = '0;
                acc_next    = '0;
                neg_next    = 1'b0;
                name_next   = '0;
                info_next   = '0;
                struct_next = '0;
                size_next   = '0;
                skip_next   = '0;
            end
            if (start_of_region && (len_sample <= PW'(pts_pkg::MIN_REGION))) begin
                fin        = 1'b1;
                phase_next = pts_pkg::PH_DONE;
            end else if (phase_next != pts_pkg::PH_DONE) begin
                p        = pos_next;
                p1       = {1'b0, p} + (PW + 1)'(1);
                pos_next = p + PW'(1);

                case (phase_next)
                    pts_pkg::PH_NAME: begin
                        ci       = ci_take(bif_next, data_byte, acc_next, neg_next);
                        acc_next = ci.acc;
                        neg_next = ci.neg;
                        bif_next = bif_next + 3'd1;
                        if (ci.done) begin
                            if (ci.acc == '0) begin
                                rec_valid  = 1'b1;
                                rec.kind   = pts_pkg::KIND_NONE;
                                phase_next = pts_pkg::PH_DONE;
                            end else if (ci.neg ||
                                         (ci.acc >= {8'd0, name_count})) begin
                                rec_valid  = 1'b1;
                                rec.kind   = pts_pkg::KIND_BAD_NAME;
                                phase_next = pts_pkg::PH_DONE;
                            end else begin
                                name_next   = ci.acc[pts_pkg::NAME_W-1:0];
                                struct_next = '0;
                                bif_next    = '0;
                                phase_next  = pts_pkg::PH_NNUM;
                            end
                        end
                    end
                    pts_pkg::PH_NNUM, pts_pkg::PH_SNUM: begin
                        bif_next = bif_next + 3'd1;
                        if (bif_next >= 3'd4) begin
                            bif_next = '0;
                            if (phase_next == pts_pkg::PH_NNUM) begin
                                phase_next = pts_pkg::PH_INFO;
                            end else begin
                                size_done = 1'b1;
                            end
                        end
                    end
                    pts_pkg::PH_INFO: begin
                        info_next = data_byte;
                        bif_next  = '0;
                        if (data_byte[3:0] == pts_pkg::TYPE_STRUCT) begin
                            phase_next = pts_pkg::PH_SNAME;
                        end else begin
                            size_done = 1'b1;
                        end
                    end
                    pts_pkg::PH_SNAME: begin
                        ci       = ci_take(bif_next, data_byte, acc_next, neg_next);
                        acc_next = ci.acc;
                        neg_next = ci.neg;
                        bif_next = bif_next + 3'd1;
                        if (ci.done) begin
                            struct_ok   = ci.neg ? (ci.acc == '0)
                                                 : (ci.acc < {8'd0, name_count});
                            struct_next = struct_ok ?
                                {1'b1, ci.acc[pts_pkg::NAME_W-1:0]} : '0;
                            bif_next    = '0;
                            phase_next  = pts_pkg::PH_SNUM;
                        end
                    end
                    pts_pkg::PH_SIZE: begin
                        if (info_next[6:4] == pts_pkg::CODE_SIZE1) begin
                            need = 3'd1;
                        end else if (info_next[6:4] == pts_pkg::CODE_SIZE2) begin
                            need = 3'd2;
                        end else begin
                            need = 3'd4;
                        end
                        size_next = size_next | (32'(data_byte) << {bif_next[1:0], 3'b000});
                        bif_next  = bif_next + 3'd1;
                        if (bif_next >= need) begin
                            bif_next = '0;
                            phase_next = pts_pkg::PH_SKIP;
                            size_done = 1'b1;
                        end
                    end
                    pts_pkg::PH_ARRAY: begin
                        if (data_byte[7:6] == 2'b10) begin
                            extra = 2'd1;
                        end else if (data_byte[7:6] == 2'b11) begin
                            extra = 2'd3;
                        end else begin
                            extra = 2'd0;
                        end
                        emit_req = 1'b1;
                    end
                    pts_pkg::PH_SKIP: begin
                        if (skip_next != '0) begin
                            skip_next = skip_next - 32'd1;
                        end
                        if (skip_next == '0) begin
                            bif_next   = '0;
                            phase_next = pts_pkg::PH_NAME;
                        end
                    end
                    default: begin
                        phase_next = pts_pkg::PH_DONE;
                    end
                endcase

                // start of payload size, taken from the code or from bytes
                if (size_done && (phase_next != pts_pkg::PH_SKIP)) begin
                    bif_next = '0;
                    if (info_next[6:4] < pts_pkg::CODE_SIZE1) begin
                        size_next = pts_pkg::fixed_size(info_next[6:4]);
                    end else begin
                        size_next  = '0;
                        phase_next = pts_pkg::PH_SIZE;
                        size_done  = 1'b0;
                    end
                end

                if (size_done) begin
                    if ((info_next[3:0] != pts_pkg::TYPE_BOOL) && info_next[7]) begin
                        phase_next = pts_pkg::PH_ARRAY;
                    end else begin
                        emit_req = 1'b1;
                    end
                end

                if (emit_req) begin
                    voff                  = pts_pkg::SUM_W'(p1) + pts_pkg::SUM_W'(extra);
                    next5                 = voff + pts_pkg::SUM_W'(size_next)
                                            + pts_pkg::SUM_W'(pts_pkg::MIN_REGION);
                    rec_valid             = 1'b1;
                    rec.kind              = pts_pkg::KIND_PROP;
                    rec.name_index        = name_next;
                    rec.tag_type          = info_next[3:0];
                    rec.payload_size      = size_next;
                    rec.value_offset      = voff[pts_pkg::NAME_W-1:0];
                    rec.struct_name_index = struct_next[pts_pkg::NAME_W-1:0];
                    rec.struct_name_valid = struct_next[pts_pkg::NAME_W];
                    rec.array_flag        = info_next[7];
                    if (next5 >= pts_pkg::SUM_W'(len_next)) begin
                        fin        = 1'b1;
                        phase_next = pts_pkg::PH_DONE;
                    end else begin
                        skip_next  = size_next + pts_pkg::SIZE_W'(extra);
                        bif_next   = '0;
                        phase_next = (skip_next != '0) ? pts_pkg::PH_SKIP
                                                       : pts_pkg::PH_NAME;
                    end
                end

                // header needs a byte past the region end
                if ((phase_next != pts_pkg::PH_DONE) && (phase_next != pts_pkg::PH_SKIP)
                    && (p1 >= {1'b0, len_next})) begin
                    fin        = 1'b1;
                    phase_next = pts_pkg::PH_DONE;
                end
            end
        end
    end

    always_comb begin
        fin_rec      = '0;
        fin_rec.kind = pts_pkg::KIND_EXHAUST;
        fin_rec.last = 1'b1;
        push         = '0;
        push.count   = {1'b0, rec_valid} + {1'b0, fin};
        if (rec_valid) begin
            push.rec0      = rec;
            push.rec0.last = !fin;
            push.rec1      = fin_rec;
        end else begin
            push.rec0 = fin_rec;
            push.rec1 = fin_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= pts_pkg::PH_DONE;
            pos_reg    <= '0;
            len_reg    <= '0;
            bif_reg    <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            name_reg   <= '0;
            info_reg   <= '0;
            struct_reg <= '0;
            size_reg   <= '0;
            skip_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            bif_reg    <= bif_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            name_reg   <= name_next;
            info_reg   <= info_next;
            struct_reg <= struct_next;
            size_reg   <= size_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

### rtl/property_tag_stream_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// property_tag_stream_parser_core
// Walks tagged property headers of a serialized object region byte by byte.
// ----------------------------------------------------------------------------
// The block takes one region byte per beat and one beat per cycle while s_tready
// is high; each byte updates the header walk state and gives zero, one or two
// records (property, None terminator, bad name, region exhausted), which wait
// in a four-entry result queue. s_tready drops only while that queue holds
// more than two records, so input flows at one byte a cycle as long as the
// result side keeps up. A beat with s_tuser set starts a new region and
// samples its length; bytes outside a walk give no record. name_count is
// written through the cfg channel, which is always ready.
module property_tag_stream_parser_core #(
    parameter int POSITION_WIDTH = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // data_byte, region_length
    input  logic          s_tuser,   // start_of_region
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // name_index, tag_type, payload_size, value_offset,
                                     // struct_name_index, struct_name_valid, array_flag
    output logic [1:0]    m_tuser,   // record_kind
    output logic          m_tlast,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [23:0]   cfg_data
);

    localparam int REC_W = $bits(pts_pkg::pts_rec_t);

    logic [pts_pkg::NAME_W-1:0] name_count_reg;
    logic                       in_accept;
    logic                       space_ok;
    pts_pkg::pts_push_t         push;
    pts_pkg::pts_rec_t          head;
    logic [REC_W-1:0]           head_bits;

    assign cfg_ready = 1'b1;
    assign s_tready  = space_ok;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            name_count_reg <= cfg_data;
        end
    end

    pts_parser #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (in_accept),
        .data_byte       (s_tdata[7:0]),
        .start_of_region (s_tuser),
        .region_length   (s_tdata[31:8]),
        .name_count      (name_count_reg),
        .push            (push)
    );

    pts_fifo #(
        .WIDTH (REC_W),
        .DEPTH (4)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push.count),
        .push_data0 (push.rec0),
        .push_data1 (push.rec1),
        .space_ok   (space_ok),
        .out_valid  (m_tvalid),
        .out_data   (head_bits),
        .out_ready  (m_tready)
    );

    assign head    = pts_pkg::pts_rec_t'(head_bits);
    assign m_tuser = head.kind;
    assign m_tlast = head.last;
    assign m_tdata = {2'b00, head.array_flag, head.struct_name_valid,
                      head.struct_name_index, head.value_offset,
                      head.payload_size, head.tag_type, head.name_index};

endmodule

### dv/tb_property_tag_stream_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_property_tag_stream_parser_core
// Self-checking bench for the tagged property header parser. Regions of
// well-formed headers with random names, types, size codes, struct names and
// array bytes are streamed in with noise regions and broken lengths mixed in.
// A header walk predictor inside a small scoreboard works out every record
// and each record beat is checked field by field, under several name table
// sizes and several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_property_tag_stream_parser_core;

    typedef longint unsigned u64_t;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 200;

    class tag_scoreboard;
        logic [23:0]                 name_count  = '0;
        logic [pts_pkg::PHASE_W-1:0] phase       = pts_pkg::PH_DONE;
        logic [23:0]                 position    = '0;
        logic [23:0]                 length_held = '0;
        logic [2:0]                  field_byte  = '0;
        logic [31:0]                 index_acc   = '0;
        logic                        index_neg   = 1'b0;
        logic [23:0]                 held_name   = '0;
        logic [7:0]                  held_info   = '0;
        logic [24:0]                 held_struct = '0;
        logic [31:0]                 size_acc    = '0;
        logic [31:0]                 skip_left   = '0;
        pts_pkg::pts_rec_t           expected_q[$];
        int                          errors      = 0;

        function void add_expected(pts_pkg::pts_rec_t r);
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void push_kind(logic [pts_pkg::KIND_W-1:0] kind);
            pts_pkg::pts_rec_t r;
            r = '0;
            r.kind = kind;
            add_expected(r);
        endfunction

        function void end_walk();
            push_kind(pts_pkg::KIND_EXHAUST);
            phase = pts_pkg::PH_DONE;
        endfunction

        // one compact index byte, returns 1 once the index is complete
        function bit take_index(logic [7:0] b);
            logic [2:0] i;
            i = field_byte;
            field_byte = i + 3'd1;
            if (i == 3'd0) begin
                index_neg = b[7];
                index_acc = {26'd0, b[5:0]};
                return !b[6];
            end
            if (i >= 3'd4) begin
                index_acc |= {b[4:0], 27'd0};
                return 1'b1;
            end
            index_acc |= 32'(b[6:0]) << (6 + (i - 1) * 7);
            return !b[7];
        endfunction

        function void emit_property(logic [23:0] p, u64_t voff);
            pts_pkg::pts_rec_t r;
            u64_t              nxt;
            nxt = voff + size_acc;
            r = '0;
            r.kind              = pts_pkg::KIND_PROP;
            r.name_index        = held_name;
            r.tag_type          = held_info[3:0];
            r.payload_size      = size_acc;
            r.value_offset      = voff[23:0];
            r.struct_name_index = held_struct[23:0];
            r.struct_name_valid = held_struct[24];
            r.array_flag        = held_info[7];
            add_expected(r);
            if (nxt + 5 >= u64_t'(length_held)) begin
                end_walk();
            end else begin
                skip_left = 32'(nxt - (u64_t'(p) + 1));
                field_byte = '0;
                phase = (skip_left != 0) ? pts_pkg::PH_SKIP : pts_pkg::PH_NAME;
            end
        endfunction

        function void after_size(logic [23:0] p);
            if (held_info[3:0] != pts_pkg::TYPE_BOOL && held_info[7]) begin
                phase = pts_pkg::PH_ARRAY;
            end else begin
                emit_property(p, u64_t'(p) + 1);
            end
        endfunction

        function void begin_size(logic [23:0] p);
            field_byte = '0;
            case (held_info[6:4])
                3'd0: size_acc = 32'd1;
                3'd1: size_acc = 32'd2;
                3'd2: size_acc = 32'd4;
                3'd3: size_acc = 32'd12;
                3'd4: size_acc = 32'd16;
                default: size_acc = '0;
            endcase
            if (held_info[6:4] < pts_pkg::CODE_SIZE1) begin
                after_size(p);
            end else begin
                phase = pts_pkg::PH_SIZE;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic start, logic [23:0] len);
            int                n0;
            int                need;
            logic [23:0]       p;
            logic [1:0]        extra;
            pts_pkg::pts_rec_t r;
            n0 = expected_q.size();
            if (start) begin
                phase       = pts_pkg::PH_NAME;
                position    = '0;
                length_held = len;
                field_byte  = '0;
                index_acc   = '0;
                index_neg   = 1'b0;
                held_name   = '0;
                held_info   = '0;
                held_struct = '0;
                size_acc    = '0;
                skip_left   = '0;
                if (length_held <= 24'(pts_pkg::MIN_REGION)) end_walk();
            end
            if (phase != pts_pkg::PH_DONE) begin
                p = position;
                position = p + 24'd1;
                case (phase)
                    pts_pkg::PH_NAME: begin
                        if (take_index(b)) begin
                            if (index_acc == 0) begin
                                push_kind(pts_pkg::KIND_NONE);
                                phase = pts_pkg::PH_DONE;
                            end else if (index_neg || index_acc >= {8'd0, name_count}) begin
                                push_kind(pts_pkg::KIND_BAD_NAME);
                                phase = pts_pkg::PH_DONE;
                            end else begin
                                held_name = index_acc[23:0];
                                held_struct = '0;
                                field_byte = '0;
                                phase = pts_pkg::PH_NNUM;
                            end
                        end
                    end
                    pts_pkg::PH_NNUM, pts_pkg::PH_SNUM: begin
                        field_byte = field_byte + 3'd1;
                        if (field_byte >= 3'd4) begin
                            field_byte = '0;
                            if (phase == pts_pkg::PH_NNUM) phase = pts_pkg::PH_INFO;
                            else begin_size(p);
                        end
                    end
                    pts_pkg::PH_INFO: begin
                        held_info = b;
                        field_byte = '0;
                        if (b[3:0] == pts_pkg::TYPE_STRUCT) phase = pts_pkg::PH_SNAME;
                        else begin_size(p);
                    end
                    pts_pkg::PH_SNAME: begin
                        if (take_index(b)) begin
                            if (index_neg ? (index_acc == 0) : (index_acc < {8'd0, name_count}))
                                held_struct = {1'b1, index_acc[23:0]};
                            else
                                held_struct = '0;
                            field_byte = '0;
                            phase = pts_pkg::PH_SNUM;
                        end
                    end
                    pts_pkg::PH_SIZE: begin
                        need = (held_info[6:4] == pts_pkg::CODE_SIZE1) ? 1 :
                               (held_info[6:4] == pts_pkg::CODE_SIZE2) ? 2 : 4;
                        size_acc |= 32'(b) << (8 * field_byte[1:0]);
                        field_byte = field_byte + 3'd1;
                        if (field_byte >= need) begin
                            field_byte = '0;
                            after_size(p);
                        end
                    end
                    pts_pkg::PH_ARRAY: begin
                        extra = (b[7:6] == 2'b10) ? 2'd1 : (b[7:6] == 2'b11) ? 2'd3 : 2'd0;
                        emit_property(p, u64_t'(p) + 1 + extra);
                    end
                    pts_pkg::PH_SKIP: begin
                        if (skip_left > 0) skip_left--;
                        if (skip_left == 0) begin
                            field_byte = '0;
                            phase = pts_pkg::PH_NAME;
                        end
                    end
                    default: phase = pts_pkg::PH_DONE;
                endcase
                if (phase != pts_pkg::PH_DONE && phase != pts_pkg::PH_SKIP &&
                    u64_t'(p) + 1 >= u64_t'(length_held))
                    end_walk();
            end
            if (expected_q.size() > n0) begin
                r = expected_q.pop_back();
                r.last = 1'b1;
                add_expected(r);
            end
        endfunction

        function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
                errors++;
            end
        endfunction

        function void check_record(pts_pkg::pts_rec_t got);
            pts_pkg::pts_rec_t want;
            if (expected_q.size() == 0) begin
                $error("record kind %0d arrived with nothing expected", got.kind);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("record_kind", want.kind, got.kind);
            compare_field("name_index", want.name_index, got.name_index);
            compare_field("tag_type", want.tag_type, got.tag_type);
            compare_field("payload_size", want.payload_size, got.payload_size);
            compare_field("value_offset", want.value_offset, got.value_offset);
            compare_field("struct_name_index", want.struct_name_index, got.struct_name_index);
            compare_field("struct_name_valid", want.struct_name_valid, got.struct_name_valid);
            compare_field("array_flag", want.array_flag, got.array_flag);
            compare_field("last_of_run", want.last, got.last);
        endfunction
    endclass

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [31:0]   s_tdata   = '0;
    logic          s_tuser   = 1'b0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [111:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [23:0]   cfg_data  = '0;

    tag_scoreboard sb = new;
    logic [7:0]    region_bytes[$];
    int            cur_names    = 0;
    int            idle_pct     = 0;
    int            stall_pct    = 0;
    int            hold_trigger = 0;
    int            hold_seen    = 0;
    int            hold_left    = 0;
    int            bytes_sent   = 0;

    property_tag_stream_parser_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : beat_monitor
        pts_pkg::pts_rec_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata[7:0], s_tuser, s_tdata[31:8]);
            if (m_tvalid && m_tready) begin
                got.kind              = m_tuser;
                got.name_index        = m_tdata[23:0];
                got.tag_type          = m_tdata[27:24];
                got.payload_size      = m_tdata[59:28];
                got.value_offset      = m_tdata[83:60];
                got.struct_name_index = m_tdata[107:84];
                got.struct_name_valid = m_tdata[108];
                got.array_flag        = m_tdata[109];
                got.last              = m_tlast;
                sb.check_record(got);
            end
        end
    end

    function automatic void add_byte(logic [7:0] b);
        region_bytes.insert(region_bytes.size(), b);
    endfunction

    function automatic void put_random(int count);
        repeat (count) add_byte(8'($urandom));
    endfunction

    function automatic void put_index(logic sign, logic [31:0] val, int forced);
        int minlen;
        int len;
        minlen = (val < 32'h40) ? 1 : (val < 32'h2000) ? 2 : (val < 32'h10_0000) ? 3 :
                 (val < 32'h800_0000) ? 4 : 5;
        len = (forced > minlen) ? forced : minlen;
        add_byte({sign, (len > 1), val[5:0]});
        for (int k = 1; k < len; k++) begin
            if (k < 4) add_byte({(k < len - 1), val[6 + 7 * (k - 1) +: 7]});
            else add_byte({3'($urandom), val[31:27]});
        end
    endfunction

    // mostly names inside the table, the rest negative, zero or past the end
    function automatic void put_name(bit is_struct);
        logic        sign;
        logic [31:0] val;
        int          r;
        int          top;
        sign = 1'b0;
        r = $urandom_range(99);
        top = (cur_names - 1 < 60) ? cur_names - 1 : 60;
        if (cur_names > 1 && r < (is_struct ? 70 : 92)) begin
            val = ($urandom_range(3) == 0) ? $urandom_range(1, cur_names - 1) :
                                             $urandom_range(1, top);
        end else if (is_struct && r < 85) begin
            val = '0;
            sign = $urandom_range(1);
        end else begin
            case ($urandom_range(2))
                0: begin
                    sign = 1'b1;
                    val = $urandom_range(0, 3000);
                end
                1: val = cur_names + $urandom_range(0, 40);
                default: begin
                    sign = $urandom_range(1);
                    val = $urandom;
                end
            endcase
        end
        put_index(sign, val, ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 1);
    endfunction

    function automatic logic [23:0] build_region();
        int          r;
        int          code;
        int          total;
        logic [3:0]  ttype;
        logic        arr;
        logic [31:0] size;
        logic [7:0]  ab;
        region_bytes.delete();
        if ($urandom_range(9) == 0) begin
            put_random($urandom_range(1, 20));
            return 24'($urandom_range(0, 30));
        end
        repeat ($urandom_range(0, 3)) begin
            put_name(1'b0);
            put_random(4);
            r = $urandom_range(9);
            ttype = (r < 3) ? pts_pkg::TYPE_STRUCT : (r < 5) ? pts_pkg::TYPE_BOOL :
                                                               4'($urandom);
            code = $urandom_range(7);
            arr = ($urandom_range(2) == 0);
            add_byte({arr, 3'(code), ttype});
            if (ttype == pts_pkg::TYPE_STRUCT) begin
                put_name(1'b1);
                put_random(4);
            end
            case (code)
                0: size = 1;
                1: size = 2;
                2: size = 4;
                3: size = 12;
                4: size = 16;
                default: begin
                    size = ($urandom_range(19) == 0) ? ($urandom >> $urandom_range(31)) :
                                                       $urandom_range(0, 16);
                    if (code == 5) size &= 32'hFF;
                    if (code == 6) size &= 32'hFFFF;
                    for (int k = 0; k < ((code == 7) ? 4 : code - 4); k++)
                        add_byte(size[8 * k +: 8]);
                end
            endcase
            if (arr && ttype != pts_pkg::TYPE_BOOL) begin
                ab = $urandom;
                add_byte(ab);
                put_random((ab[7:6] == 2'b10) ? 1 : (ab[7:6] == 2'b11) ? 3 : 0);
            end
            put_random((size > 40) ? 40 : int'(size));
        end
        if ($urandom_range(4) < 3) add_byte({1'($urandom_range(1)), 7'h00});
        if (region_bytes.size() == 0) put_random(1);
        total = region_bytes.size();
        r = $urandom_range(19);
        if (r < 14) return 24'(total);
        if (r < 17) return 24'($urandom_range(0, total));
        if (r < 19) return 24'(total + $urandom_range(1, 20));
        return 24'($urandom);
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic start, input logic [23:0] len);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, b};
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_region(input logic [23:0] len);
        foreach (region_bytes[k])
            send_beat(region_bytes[k], (k == 0), (k == 0) ? len : 24'($urandom));
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_names(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= 24'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.name_count = 24'(value);
        cur_names = value;
    endtask

    task automatic run_phase(input int names, input int idle, input int stall, input bit hold);
        int first;
        logic [23:0] len;
        drain();
        write_names(names);
        idle_pct = idle;
        stall_pct <= stall;
        if (hold) hold_trigger <= hold_trigger + 1;
        first = bytes_sent;
        while (bytes_sent - first < PHASE_BYTES) begin
            len = build_region();
            send_region(len);
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_names(40);

        // byte before any region start is ignored
        send_beat(8'hA5, 1'b0, 24'd0);
        // regions too short to hold a tag
        region_bytes = '{8'h00};
        send_region(24'd0);
        region_bytes = '{8'hFF};
        send_region(24'd5);
        // None terminator, positive and negative zero
        region_bytes = '{8'h00};
        send_region(24'hFFFFFF);
        region_bytes = '{8'h80};
        send_region(24'd20);
        // bad names: negative, past the table
        region_bytes = '{8'h81};
        send_region(24'd20);
        region_bytes = '{8'h3F};
        send_region(24'd20);
        // bool with array flag, walk ends right after the property
        region_bytes = '{8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h83};
        send_region(24'd9);
        // size byte would lie past the region end
        region_bytes = '{8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h72};
        send_region(24'd6);
        s_tvalid <= 1'b0;

        run_phase(0, 60, 0, 1'b0);
        run_phase(24'hFFFFFF, 0, 60, 1'b1);
        run_phase($urandom_range(2, 5000), 11, 11, 1'b0);
        run_phase(1, 0, 0, 1'b0);
        run_phase(300, 11, 11, 1'b0);
        drain();

        if (sb.errors == 0) begin
            $display("property_tag_stream_parser_core verification clean");
        end else begin
            $display("property_tag_stream_parser_core verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("property_tag_stream_parser_core verification failed");
        $finish;
    end

endmodule
